// File: rtl/sarg_pkg.sv
package sarg_pkg;

    localparam int SERVO_COUNT_DEF = 4;

    localparam logic [7:0]  STEP_RST  = 8'd5;
    localparam logic [14:0] MIN_RST   = 15'd500;
    localparam logic [14:0] MAX_RST   = 15'd2500;

    localparam logic signed [7:0] ANGLE_MIN = -8'sd90;
    localparam logic signed [7:0] ANGLE_MAX = 8'sd90;
    localparam logic [7:0]        STEP_FLOOR = 8'd3;
    localparam logic [7:0]        ANGLE_SPAN = 8'd180;

    // ceil(2^27 / 45): x / 180 equals ((x >> 2) * PULSE_RECIP) >> 27 for x below 2^23
    localparam logic [21:0] PULSE_RECIP = 22'd2982617;

    localparam int DIV_DW = 23;
    localparam int DIV_VW = 8;

    localparam logic [1:0] REG_STEP = 2'd0;
    localparam logic [1:0] REG_MIN  = 2'd1;
    localparam logic [1:0] REG_MAX  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_STEP_DIV,
        ST_POS_MUL,
        ST_POS_DIV,
        ST_PULSE_MUL,
        ST_PULSE_DIV,
        ST_EMIT
    } state_t;

endpackage

// File: rtl/sarg_div.sv
module sarg_div #(
    parameter int DW = sarg_pkg::DIV_DW,
    parameter int VW = sarg_pkg::DIV_VW
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          done_reg;
    logic          done_next;
    logic [DW-1:0] quo_reg;
    logic [DW-1:0] quo_next;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] rem_next;
    logic [VW-1:0] dvs_reg;
    logic [VW-1:0] dvs_next;
    logic [VW:0]   trial;
    logic [VW:0]   diff;

    assign busy     = (cnt_reg != '0);
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DW-1]};
        diff      = trial - {1'b0, dvs_reg};
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            cnt_next = CW'(DW);
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (busy)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
            if (!diff[VW])
            begin
                rem_next = diff[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

endmodule

// File: rtl/servo_angle_ramp_generator.sv
// channel   direction  handshake          payload
// s_*       in         s_tvalid/s_tready  s_tdata: servo_sel, target_angle
// m_*       out        m_tvalid/m_tready  m_tdata: channel, position, compare_value; m_tlast
// cfg_*     in         cfg_we             cfg_addr, cfg_wdata
//
// one shared 23-bit restoring divider finds the step count and
// each intermediate position; the compare value uses a reciprocal multiply in ST_PULSE_MUL and ST_PULSE_DIV
// an item occupies the block from accept to ready again, output stall time included
// s_tready is high only in idle; a stalled result holds the sequencer in place
// reset clears held angles to zero and loads register defaults
module servo_angle_ramp_generator #(
    parameter int SERVO_COUNT = sarg_pkg::SERVO_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // servo_sel[1:0], target_angle[9:2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // channel[1:0], position[9:2], compare_value[24:10]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [14:0] cfg_wdata
);

    localparam int DW = sarg_pkg::DIV_DW;
    localparam int VW = sarg_pkg::DIV_VW;

    sarg_pkg::state_t state_reg, state_next;

    logic [7:0]  step_reg;
    logic [14:0] min_reg;
    logic [14:0] max_reg;
    logic [7:0]  held_reg [SERVO_COUNT];

    logic [1:0]  sel_reg,  sel_next;
    logic [7:0]  tgt_reg,  tgt_next;
    logic [7:0]  cur_reg,  cur_next;
    logic        neg_reg,  neg_next;
    logic [7:0]  mag_reg,  mag_next;
    logic [5:0]  steps_reg, steps_next;
    logic [5:0]  j_reg,    j_next;
    logic [7:0]  pos_reg,  pos_next;
    logic        fin_reg,  fin_next;
    logic [22:0] prod_reg, prod_next;
    logic [7:0]  out_pos_reg, out_pos_next;
    logic [14:0] out_cmp_reg, out_cmp_next;
    logic        out_last_reg, out_last_next;

    logic        held_we;
    logic [7:0]  cur_rd;
    logic signed [7:0] in_tgt;
    logic [7:0]  in_sat;
    logic [7:0]  step_eff;
    logic [8:0]  delta;
    logic [8:0]  delta_mag;
    logic [13:0] pos_prod;
    logic [6:0]  j_inc;
    logic [8:0]  ang_off;
    logic [15:0] span;
    logic [15:0] span_abs;
    logic [22:0] pulse_prod;
    logic [42:0] recip_prod;
    logic [9:0]  pos_sum;
    logic [15:0] cmp_sum;
    logic [7:0]  q_pos;
    logic [14:0] q_cmp;

    logic          div_start;
    logic [DW-1:0] div_dividend;
    logic [VW-1:0] div_divisor;
    logic          div_busy;
    logic          div_done;
    logic [DW-1:0] div_q;

    sarg_div #(
        .DW(DW),
        .VW(VW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign s_tready = (state_reg == sarg_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == sarg_pkg::ST_EMIT);
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'd0, out_cmp_reg, out_pos_reg, sel_reg};

    // held angle read for the selected servo
    always_comb
    begin
        cur_rd = '0;
        for (int i = 0; i < SERVO_COUNT; i++)
        begin
            if (32'(sel_reg) == i)
            begin
                cur_rd = held_reg[i];
            end
        end
    end

    always_comb
    begin
        in_tgt = $signed(s_tdata[9:2]);
        if (in_tgt < sarg_pkg::ANGLE_MIN)
        begin
            in_sat = sarg_pkg::ANGLE_MIN;
        end
        else if (in_tgt > sarg_pkg::ANGLE_MAX)
        begin
            in_sat = sarg_pkg::ANGLE_MAX;
        end
        else
        begin
            in_sat = s_tdata[9:2];
        end

        step_eff  = (step_reg < sarg_pkg::STEP_FLOOR) ? sarg_pkg::STEP_FLOOR : step_reg;
        delta     = {tgt_reg[7], tgt_reg} - {cur_rd[7], cur_rd};
        delta_mag = delta[8] ? (9'd0 - delta) : delta;
        j_inc     = {1'b0, j_reg} + 7'd1;
        pos_prod  = 14'(mag_reg) * 14'(j_inc);
        ang_off   = {pos_reg[7], pos_reg} + 9'd90;
        span      = {1'b0, max_reg} - {1'b0, min_reg};
        span_abs  = span[15] ? (16'd0 - span) : span;
        pulse_prod = 23'(ang_off[7:0]) * 23'(span_abs[14:0]);
        // divide by 180 as a quarter times the reciprocal of 45
        recip_prod = 43'(prod_reg[22:2]) * 43'(sarg_pkg::PULSE_RECIP);
        q_pos     = div_q[7:0];
        q_cmp     = recip_prod[41:27];
        pos_sum   = {{2{cur_reg[7]}}, cur_reg}
                  + (neg_reg ? (10'd0 - {2'd0, q_pos}) : {2'd0, q_pos});
        cmp_sum   = {1'b0, min_reg}
                  + (span[15] ? (16'd0 - {1'b0, q_cmp}) : {1'b0, q_cmp});
    end

    always_comb
    begin
        state_next    = state_reg;
        sel_next      = sel_reg;
        tgt_next      = tgt_reg;
        cur_next      = cur_reg;
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        steps_next    = steps_reg;
        j_next        = j_reg;
        pos_next      = pos_reg;
        fin_next      = fin_reg;
        prod_next     = prod_reg;
        out_pos_next  = out_pos_reg;
        out_cmp_next  = out_cmp_reg;
        out_last_next = out_last_reg;
        held_we       = 1'b0;
        div_start     = 1'b0;
        div_dividend  = '0;
        div_divisor   = '0;

        unique case (state_reg)
            sarg_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    sel_next = s_tdata[1:0];
                    tgt_next = in_sat;
                    if (32'(s_tdata[1:0]) < SERVO_COUNT)
                    begin
                        state_next = sarg_pkg::ST_LOAD;
                    end
                end
            end
            sarg_pkg::ST_LOAD:
            begin
                cur_next     = cur_rd;
                neg_next     = delta[8];
                mag_next     = delta_mag[7:0];
                held_we      = 1'b1;
                div_start    = 1'b1;
                div_dividend = DW'(delta_mag[7:0]);
                div_divisor  = step_eff;
                state_next   = sarg_pkg::ST_STEP_DIV;
            end
            sarg_pkg::ST_STEP_DIV:
            begin
                if (div_done)
                begin
                    steps_next = div_q[5:0];
                    j_next     = '0;
                    if (div_q[5:0] == 6'd0)
                    begin
                        pos_next   = tgt_reg;
                        fin_next   = 1'b1;
                        state_next = sarg_pkg::ST_PULSE_MUL;
                    end
                    else
                    begin
                        fin_next   = 1'b0;
                        state_next = sarg_pkg::ST_POS_MUL;
                    end
                end
            end
            sarg_pkg::ST_POS_MUL:
            begin
                div_start    = 1'b1;
                div_dividend = DW'(pos_prod);
                div_divisor  = VW'(steps_reg);
                state_next   = sarg_pkg::ST_POS_DIV;
            end
            sarg_pkg::ST_POS_DIV:
            begin
                if (div_done)
                begin
                    pos_next   = pos_sum[7:0];
                    state_next = sarg_pkg::ST_PULSE_MUL;
                end
            end
            sarg_pkg::ST_PULSE_MUL:
            begin
                prod_next  = pulse_prod;
                state_next = sarg_pkg::ST_PULSE_DIV;
            end
            sarg_pkg::ST_PULSE_DIV:
            begin
                out_pos_next  = pos_reg;
                out_cmp_next  = cmp_sum[14:0];
                out_last_next = fin_reg;
                state_next    = sarg_pkg::ST_EMIT;
            end
            sarg_pkg::ST_EMIT:
            begin
                if (m_tready)
                begin
                    if (fin_reg)
                    begin
                        state_next = sarg_pkg::ST_IDLE;
                    end
                    else
                    begin
                        j_next = j_inc[5:0];
                        if (j_inc[5:0] == steps_reg)
                        begin
                            pos_next   = tgt_reg;
                            fin_next   = 1'b1;
                            state_next = sarg_pkg::ST_PULSE_MUL;
                        end
                        else
                        begin
                            state_next = sarg_pkg::ST_POS_MUL;
                        end
                    end
                end
            end
            default:
            begin
                state_next = sarg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sarg_pkg::ST_IDLE;
            step_reg  <= sarg_pkg::STEP_RST;
            min_reg   <= sarg_pkg::MIN_RST;
            max_reg   <= sarg_pkg::MAX_RST;
            for (int i = 0; i < SERVO_COUNT; i++)
            begin
                held_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    sarg_pkg::REG_STEP: step_reg <= cfg_wdata[7:0];
                    sarg_pkg::REG_MIN:  min_reg  <= cfg_wdata;
                    sarg_pkg::REG_MAX:  max_reg  <= cfg_wdata;
                    default:            ;
                endcase
            end
            for (int i = 0; i < SERVO_COUNT; i++)
            begin
                if (held_we && (32'(sel_reg) == i))
                begin
                    held_reg[i] <= tgt_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg      <= sel_next;
        tgt_reg      <= tgt_next;
        cur_reg      <= cur_next;
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        steps_reg    <= steps_next;
        j_reg        <= j_next;
        pos_reg      <= pos_next;
        fin_reg      <= fin_next;
        prod_reg     <= prod_next;
        out_pos_reg  <= out_pos_next;
        out_cmp_reg  <= out_cmp_next;
        out_last_reg <= out_last_next;
    end

    a_final_at_target: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (out_pos_reg == tgt_reg))
        else $error("final result not at target");

    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == sarg_pkg::ST_STEP_DIV
                      || state_reg == sarg_pkg::ST_POS_DIV))
        else $error("divider finished outside a wait state");

    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !div_busy)
        else $error("divider busy while idle");

    a_ready_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("not ready after final result");

endmodule

// File: dv/tb_servo_angle_ramp_generator.sv
`timescale 1ns / 100ps

module tb_servo_angle_ramp_generator;

    localparam int          SERVO_COUNT   = sarg_pkg::SERVO_COUNT_DEF;
    localparam logic [1:0]  REG_NONE      = 2'd3;
    localparam int          QUIET_LIMIT   = 2000;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          DRAIN_CYCLES  = 200;

    typedef struct packed {
        logic [1:0]        ch;
        logic signed [7:0] pos;
        logic [14:0]       cmp;
        logic              fin;
    } ramp_step_t;

    typedef enum logic {
        ROW_TARGET,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [1:0]        sel;
        logic [7:0]        angle;
        logic [14:0]       value;
        logic              typed;
        logic signed [7:0] want_pos;
        logic [14:0]       want_cmp;
    } plan_row_t;

    localparam int DIRECTED_ROWS = 28;

    localparam plan_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_TARGET, 2'd0, 8'd0,     15'd0,     1'b1, 8'sd0,   15'd1500},
        '{ROW_TARGET, 2'd1, 8'd2,     15'd0,     1'b1, 8'sd2,   15'd1522},
        '{ROW_TARGET, 2'd0, 8'd90,    15'd0,     1'b0, 8'sd0,   15'd0},
        '{ROW_TARGET, 2'd0, 8'h7F,    15'd0,     1'b1, 8'sd90,  15'd2500},
        '{ROW_TARGET, 2'd0, 8'h80,    15'd0,     1'b0, 8'sd0,   15'd0},
        '{ROW_TARGET, 2'd0, 8'hA5,    15'd0,     1'b1, -8'sd90, 15'd500},
        '{ROW_TARGET, 2'd2, 8'hA6,    15'd0,     1'b0, 8'sd0,   15'd0},
        '{ROW_TARGET, 2'd3, 8'd89,    15'd0,     1'b0, 8'sd0,   15'd0},
        '{ROW_TARGET, 2'd3, 8'd90,    15'd0,     1'b1, 8'sd90,  15'd2500},
        '{ROW_TARGET, 2'd1, 8'hFF,    15'd0,     1'b1, -8'sd1,  15'd1488},
        '{ROW_TARGET, 2'd1, 8'd4,     15'd0,     1'b0, 8'sd0,   15'd0},
        '{ROW_TARGET, 2'd2, 8'd85,    15'd0,     1'b0, 8'sd0,   15'd0},
        '{ROW_TARGET, 2'd3, 8'hF9,    15'd0,     1'b0, 8'sd0,   15'd0},
        '{ROW_TARGET, 2'd1, 8'h55,    15'd0,     1'b0, 8'sd0,   15'd0},
        '{ROW_TARGET, 2'd2, 8'hAA,    15'd0,     1'b0, 8'sd0,   15'd0},
        '{ROW_WRITE,  sarg_pkg::REG_STEP, 8'd0, 15'd255,  1'b0, 8'sd0, 15'd0},
        '{ROW_TARGET, 2'd0, 8'd90,    15'd0,     1'b1, 8'sd90,  15'd2500},
        '{ROW_WRITE,  sarg_pkg::REG_MIN,  8'd0, 15'd2500, 1'b0, 8'sd0, 15'd0},
        '{ROW_WRITE,  sarg_pkg::REG_MAX,  8'd0, 15'd500,  1'b0, 8'sd0, 15'd0},
        '{ROW_TARGET, 2'd0, 8'hA6,    15'd0,     1'b1, -8'sd90, 15'd2500},
        '{ROW_TARGET, 2'd0, 8'd0,     15'd0,     1'b1, 8'sd0,   15'd1500},
        '{ROW_WRITE,  REG_NONE, 8'd0, 15'h7FFF,  1'b0, 8'sd0,   15'd0},
        '{ROW_WRITE,  sarg_pkg::REG_STEP, 8'd0, 15'd0,    1'b0, 8'sd0, 15'd0},
        '{ROW_TARGET, 2'd0, 8'd90,    15'd0,     1'b0, 8'sd0,   15'd0},
        '{ROW_WRITE,  sarg_pkg::REG_MIN,  8'd0, 15'd0,    1'b0, 8'sd0, 15'd0},
        '{ROW_WRITE,  sarg_pkg::REG_MAX,  8'd0, 15'h7FFF, 1'b0, 8'sd0, 15'd0},
        '{ROW_TARGET, 2'd1, 8'h80,    15'd0,     1'b0, 8'sd0,   15'd0},
        '{ROW_TARGET, 2'd3, 8'h7F,    15'd0,     1'b0, 8'sd0,   15'd0}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [14:0] cfg_wdata;

    ramp_step_t  ramp_due [$];
    int          held_deg [SERVO_COUNT];
    logic [7:0]  step_reg;
    logic [14:0] min_reg;
    logic [14:0] max_reg;
    int          error_count;
    int          targets_sent;
    int          quiet_cycles;
    bit          idle_on;
    bit          hold_done;

    servo_angle_ramp_generator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [14:0] pulse_ticks(input int angle);
        longint span;
        longint offset;
        longint ticks;
        span = longint'(max_reg) - longint'(min_reg);
        if (angle < sarg_pkg::ANGLE_MIN)
            angle = sarg_pkg::ANGLE_MIN;
        if (angle > sarg_pkg::ANGLE_MAX)
            angle = sarg_pkg::ANGLE_MAX;
        offset = angle - sarg_pkg::ANGLE_MIN;
        ticks = (offset * span) / 180 + longint'(min_reg);
        if (ticks < 0)
            ticks = 0;
        return ticks[14:0];
    endfunction

    function automatic void queue_step(input logic [1:0] ch, input int pos, input bit fin);
        ramp_step_t r;
        r.ch  = ch;
        r.pos = pos[7:0];
        r.cmp = pulse_ticks(pos);
        r.fin = fin;
        ramp_due.push_back(r);
    endfunction

    // predicts the ramp for one request and moves the held angle
    function automatic void plan_ramp(input logic [1:0] sel, input logic [7:0] raw,
                                      input bit keep);
        int target;
        int cur;
        int delta;
        int mag;
        int stride;
        int steps;
        int j;
        if (sel >= SERVO_COUNT)
            return;
        target = $signed(raw);
        if (target < sarg_pkg::ANGLE_MIN)
            target = sarg_pkg::ANGLE_MIN;
        if (target > sarg_pkg::ANGLE_MAX)
            target = sarg_pkg::ANGLE_MAX;
        stride = (step_reg < sarg_pkg::STEP_FLOOR) ? sarg_pkg::STEP_FLOOR : step_reg;
        cur = held_deg[sel];
        delta = target - cur;
        mag = (delta < 0) ? -delta : delta;
        steps = mag / stride;
        if (keep)
        begin
            for (j = 0; j < steps; j++)
                queue_step(sel, cur + (delta * (j + 1)) / steps, 1'b0);
            queue_step(sel, target, 1'b1);
        end
        held_deg[sel] = target;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    task automatic check_result;
        ramp_step_t got;
        ramp_step_t want;
        got.ch  = m_tdata[1:0];
        got.pos = m_tdata[9:2];
        got.cmp = m_tdata[24:10];
        got.fin = m_tlast;
        if (ramp_due.size() == 0)
        begin
            report_mismatch("unexpected result, position", $signed(got.pos), 0);
        end
        else
        begin
            want = ramp_due.pop_front();
            if (got.ch != want.ch)
                report_mismatch("channel", got.ch, want.ch);
            if (got.pos != want.pos)
                report_mismatch("position", $signed(got.pos), $signed(want.pos));
            if (got.cmp != want.cmp)
                report_mismatch("compare value", got.cmp, want.cmp);
            if (got.fin != want.fin)
                report_mismatch("last", got.fin, want.fin);
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_result();
    end

    always @(negedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: random stall bursts plus one long hold-off while requests keep coming
    initial
    begin : result_sink
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!hold_done && targets_sent >= 40)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    task automatic send_target(input logic [1:0] sel, input logic [7:0] raw, input bit typed,
                               input logic signed [7:0] want_pos, input logic [14:0] want_cmp);
        bit taken;
        ramp_step_t r;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, raw, sel};
        do
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end
        while (!taken);
        targets_sent++;
        plan_ramp(sel, raw, !typed);
        if (typed)
        begin
            r.ch  = sel;
            r.pos = want_pos;
            r.cmp = want_cmp;
            r.fin = 1'b1;
            ramp_due.push_back(r);
        end
    endtask

    task automatic wait_drained;
        while (ramp_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [14:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (addr)
            sarg_pkg::REG_STEP: step_reg = value[7:0];
            sarg_pkg::REG_MIN:  min_reg  = value;
            sarg_pkg::REG_MAX:  max_reg  = value;
            default:            ;
        endcase
    endtask

    initial
    begin : stimulus
        int          p;
        int          k;
        int          count;
        logic [7:0]  step_v;
        logic [14:0] min_v;
        logic [14:0] max_v;
        logic [1:0]  sel;
        logic [7:0]  raw;
        plan_row_t   row;

        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_we       = 1'b0;
        cfg_addr     = sarg_pkg::REG_STEP;
        cfg_wdata    = '0;
        rst_n        = 1'b0;
        error_count  = 0;
        targets_sent = 0;
        quiet_cycles = 0;
        hold_done    = 1'b0;
        idle_on      = 1'b1;
        step_reg     = sarg_pkg::STEP_RST;
        min_reg      = sarg_pkg::MIN_RST;
        max_reg      = sarg_pkg::MAX_RST;
        for (k = 0; k < SERVO_COUNT; k++)
            held_deg[k] = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (k = 0; k < DIRECTED_ROWS; k++)
        begin
            row = DIRECTED[k];
            if (row.kind == ROW_WRITE)
            begin
                s_tvalid <= 1'b0;
                wait_drained();
                write_reg(row.sel, row.value);
            end
            else
            begin
                send_target(row.sel, row.angle, row.typed, row.want_pos, row.want_cmp);
            end
        end

        for (p = 0; p < 7; p++)
        begin
            count = 70;
            case (p)
                0:
                begin
                    step_v = sarg_pkg::STEP_RST;
                    min_v  = sarg_pkg::MIN_RST;
                    max_v  = sarg_pkg::MAX_RST;
                    count  = 80;
                end
                1:
                begin
                    step_v = 8'd0; min_v = 15'd0; max_v = 15'h7FFF;
                end
                2:
                begin
                    step_v = sarg_pkg::ANGLE_SPAN; min_v = 15'd20000; max_v = 15'd0;
                end
                3:
                begin
                    step_v = 8'd255; min_v = 15'h7FFF; max_v = 15'h7FFF; count = 50;
                end
                6:
                begin
                    step_v = 8'($urandom_range(3, 30));
                    min_v  = 15'($urandom_range(0, 20000));
                    max_v  = 15'($urandom_range(0, 20000));
                end
                default:
                begin
                    step_v = 8'($urandom_range(0, 40));
                    min_v  = 15'($urandom);
                    max_v  = 15'($urandom);
                end
            endcase
            s_tvalid <= 1'b0;
            wait_drained();
            // last phase runs with no idling on either side
            idle_on = (p != 6);
            write_reg(sarg_pkg::REG_STEP, {7'($urandom), step_v});
            write_reg(sarg_pkg::REG_MIN, min_v);
            write_reg(sarg_pkg::REG_MAX, max_v);
            for (k = 0; k < count; k++)
            begin
                sel = 2'($urandom_range(0, SERVO_COUNT - 1));
                if ($urandom_range(0, 9) == 0)
                    raw = 8'($urandom);
                else
                    raw = 8'($urandom_range(0, 180) - 90);
                send_target(sel, raw, 1'b0, 8'sd0, 15'd0);
            end
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
rtl/sarg_pkg.sv
rtl/sarg_div.sv
rtl/servo_angle_ramp_generator.sv
dv/tb_servo_angle_ramp_generator.sv
